// ===== rtl/assert_macros.svh =====
// assertion macros shared by the turbulence noise rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication on the block clock, off during reset
`define TVN_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication on the block clock, off during reset
`define TVN_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/tvn_pkg.sv =====
// types, constants and codes for the turbulence noise block
package tvn_pkg;

	localparam int TABLE_SIDE_DEF  = 64;
	localparam int MAX_OCTAVES_DEF = 8;

	localparam int IDX_W    = 12;
	localparam int VAL_W    = 16;
	localparam int POS_W    = 24;
	localparam int OUT_W    = 24;
	localparam int TOP_W    = 3;
	localparam int GAIN_W   = 16;
	localparam int CFG_W    = 16;
	localparam int REG_W    = 1;
	localparam int ACC_W    = 24;
	localparam int WGT_W    = 31;
	localparam int SUM_W    = 47;
	localparam int SCALED_W = 40;

	localparam int QUEUE_DEPTH = 2;

	localparam logic [15:0]      ONE_Q15 = 16'h8000;
	localparam logic [OUT_W-1:0] OUT_MAX = 24'hFFFFFF;

	localparam logic ACT_QUERY = 1'b1;

	localparam logic [REG_W-1:0] REG_OCTAVE_TOP = 1'b0;
	localparam logic [REG_W-1:0] REG_GAIN       = 1'b1;

	typedef enum logic {
		CMD_WRITE,
		CMD_QUERY
	} tvn_cmd_kind_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_REDUCE,
		ST_READ,
		ST_DRAIN,
		ST_SCALE,
		ST_OUT
	} tvn_state_t;

	typedef struct packed {
		tvn_cmd_kind_t    kind;
		logic [IDX_W-1:0] index;
		logic [VAL_W-1:0] value;
		logic [POS_W-1:0] x;
		logic [POS_W-1:0] y;
	} tvn_cmd_t;

	typedef struct packed {
		logic pop;
		logic busy;
	} tvn_back_stat_t;

endpackage

// ===== rtl/turbulence_value_noise_core.sv =====
// top level of the value-noise turbulence block with its configuration registers
// Input channel (in_valid / in_stall): one transfer carries an item. With action
// low it writes table_value into table entry table_index (row * side + column);
// writes at or beyond the end of the table are dropped. With action high it asks
// for the turbulence at (x_pos, y_pos), unsigned Q16.8, and gives one result.
// Output channel (out_valid / out_stall): one transfer per query, turbulence in
// unsigned Q8.16, saturated at all ones.
// Configuration: cfg_write_en with cfg_index 0 sets octave_top (3 bits), index 1
// sets gain (Q8.8); write only while no query is in flight.
// Items go through a two-entry command queue into the execution side, so the
// input keeps taking items while a query runs. A write enters the table as
// the idle execution side pops it. A query wraps the cell coordinates one
// bit per cycle; each octave makes four reads on the single table read port.
// One query runs at a time; the next starts once its result sits in the output
// register. While out_stall is high the result holds and the next query stops
// before loading its own result.
// Reset empties the queue, returns to idle and loads top 4 and gain 1.0; table
// contents stay undefined until written.
`include "assert_macros.svh"

module turbulence_value_noise_core #(
	parameter int TABLE_SIDE  = tvn_pkg::TABLE_SIDE_DEF,
	parameter int MAX_OCTAVES = tvn_pkg::MAX_OCTAVES_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_write_en,
	input  logic [tvn_pkg::REG_W-1:0]    cfg_index,
	input  logic [tvn_pkg::CFG_W-1:0]    cfg_data,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic                         action,
	input  logic [tvn_pkg::IDX_W-1:0]    table_index,
	input  logic [tvn_pkg::VAL_W-1:0]    table_value,
	input  logic [tvn_pkg::POS_W-1:0]    x_pos,
	input  logic [tvn_pkg::POS_W-1:0]    y_pos,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic [tvn_pkg::OUT_W-1:0]    turbulence
);

	logic [tvn_pkg::TOP_W-1:0]  octave_top_q;
	logic [tvn_pkg::GAIN_W-1:0] gain_q;
	logic [tvn_pkg::TOP_W-1:0]  top_eff;
	logic                       cmd_valid;
	tvn_pkg::tvn_cmd_t          cmd;
	tvn_pkg::tvn_back_stat_t    back_stat;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			octave_top_q <= 3'd4;
			gain_q       <= 16'd256;
		end else if (cfg_write_en) begin
			case (cfg_index)
				tvn_pkg::REG_OCTAVE_TOP: octave_top_q <= cfg_data[tvn_pkg::TOP_W-1:0];
				tvn_pkg::REG_GAIN:       gain_q       <= cfg_data[tvn_pkg::GAIN_W-1:0];
				default: gain_q <= gain_q;
			endcase
		end
	end

	// clamp to the octaves the block supports
	always_comb begin
		top_eff = octave_top_q;
		if (int'(octave_top_q) > MAX_OCTAVES - 1) begin
			top_eff = tvn_pkg::TOP_W'(MAX_OCTAVES - 1);
		end
	end

	tvn_front #(
		.TABLE_SIDE (TABLE_SIDE)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.action      (action),
		.table_index (table_index),
		.table_value (table_value),
		.x_pos       (x_pos),
		.y_pos       (y_pos),
		.cmd_valid   (cmd_valid),
		.cmd         (cmd),
		.cmd_pop     (back_stat.pop)
	);

	tvn_back #(
		.TABLE_SIDE (TABLE_SIDE)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd_valid  (cmd_valid),
		.cmd        (cmd),
		.top        (top_eff),
		.gain       (gain_q),
		.stat       (back_stat),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.turbulence (turbulence)
	);

	`TVN_ASSERT_IMP(a_pop_needs_cmd, back_stat.pop, cmd_valid, "pop from an empty queue")
	`TVN_ASSERT_NXT(a_query_starts, back_stat.pop && cmd.kind == tvn_pkg::CMD_QUERY, back_stat.busy, "query did not start")
	`TVN_ASSERT_IMP(a_result_from_query, $rose(out_valid), $past(back_stat.busy), "result without a running query")

endmodule

// ===== rtl/tvn_front.sv =====
// input side: accepts items, drops out-of-range writes, queues commands
module tvn_front #(
	parameter int TABLE_SIDE = tvn_pkg::TABLE_SIDE_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic                         action,
	input  logic [tvn_pkg::IDX_W-1:0]    table_index,
	input  logic [tvn_pkg::VAL_W-1:0]    table_value,
	input  logic [tvn_pkg::POS_W-1:0]    x_pos,
	input  logic [tvn_pkg::POS_W-1:0]    y_pos,
	output logic                         cmd_valid,
	output tvn_pkg::tvn_cmd_t            cmd,
	input  logic                         cmd_pop
);

	localparam int ENTRIES = TABLE_SIDE * TABLE_SIDE;
	localparam int PW      = $clog2(tvn_pkg::QUEUE_DEPTH);
	localparam int CW      = $clog2(tvn_pkg::QUEUE_DEPTH + 1);

	tvn_pkg::tvn_cmd_t queue_q [tvn_pkg::QUEUE_DEPTH];
	tvn_pkg::tvn_cmd_t new_cmd;
	logic [PW-1:0]     wr_ptr_q;
	logic [PW-1:0]     rd_ptr_q;
	logic [CW-1:0]     count_q;
	logic              accept;
	logic              in_range;
	logic              push;

	assign in_stall  = (count_q == CW'(tvn_pkg::QUEUE_DEPTH));
	assign accept    = in_valid && !in_stall;
	assign in_range  = (32'(table_index) < 32'(ENTRIES));
	assign push      = accept && ((action == tvn_pkg::ACT_QUERY) || in_range);
	assign cmd_valid = (count_q != '0);
	assign cmd       = queue_q[rd_ptr_q];

	always_comb begin
		new_cmd.kind  = (action == tvn_pkg::ACT_QUERY) ? tvn_pkg::CMD_QUERY : tvn_pkg::CMD_WRITE;
		new_cmd.index = table_index;
		new_cmd.value = table_value;
		new_cmd.x     = x_pos;
		new_cmd.y     = y_pos;
	end

	always_ff @(posedge clk) begin
		if (push) begin
			queue_q[wr_ptr_q] <= new_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(tvn_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (cmd_pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(tvn_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({push, cmd_pop})
				2'b10: count_q <= count_q + 1'b1;
				2'b01: count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// ===== rtl/tvn_back.sv =====
// execution side: table memory, octave sequencer, bilinear datapath, result register
module tvn_back #(
	parameter int TABLE_SIDE = tvn_pkg::TABLE_SIDE_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cmd_valid,
	input  tvn_pkg::tvn_cmd_t             cmd,
	input  logic [tvn_pkg::TOP_W-1:0]     top,
	input  logic [tvn_pkg::GAIN_W-1:0]    gain,
	output tvn_pkg::tvn_back_stat_t       stat,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [tvn_pkg::OUT_W-1:0]     turbulence
);

	localparam int ENTRIES = TABLE_SIDE * TABLE_SIDE;
	localparam int AW      = $clog2(ENTRIES);
	localparam int RW      = $clog2(TABLE_SIDE);
	localparam logic [RW:0]   SIDE_R  = (RW + 1)'(TABLE_SIDE);
	localparam logic [RW-1:0] SIDE_M1 = RW'(TABLE_SIDE - 1);

	localparam logic [4:0] BIT_TOP = 5'd23;
	localparam logic [4:0] BIT_LOW = 5'd8;

	tvn_pkg::tvn_state_t state_q, state_d;

	logic [tvn_pkg::VAL_W-1:0] noise_mem [ENTRIES];

	logic [tvn_pkg::POS_W-1:0]    x_q, y_q;
	logic [tvn_pkg::TOP_W-1:0]    top_q;
	logic [4:0]                   b_q;
	logic [1:0]                   corner_q;
	logic [RW-1:0]                rx_q, ry_q;
	logic [tvn_pkg::ACC_W-1:0]    acc_q;
	logic [tvn_pkg::SCALED_W-1:0] scaled_q;
	logic [tvn_pkg::SUM_W-1:0]    ssum_q;

	logic [tvn_pkg::WGT_W-1:0]    weight_s1;
	logic [tvn_pkg::VAL_W-1:0]    rdata_s1;
	logic                         v_s1, first_s1, last_s1;
	logic [2:0]                   k_s1;
	logic [tvn_pkg::SUM_W-1:0]    prod_s2;
	logic                         v_s2, first_s2, last_s2;
	logic [2:0]                   k_s2;
	logic                         fold_s3;
	logic [2:0]                   k_s3;

	logic                         out_valid_q;
	logic [tvn_pkg::OUT_W-1:0]    turb_q;

	logic                         pop, start, mem_we, issue, out_load, pipe_empty;
	logic                         reduce_done;
	logic [2:0]                   k_cur;
	logic [30:0]                  xs, ys;
	logic [14:0]                  fx, fy;
	logic [15:0]                  gx, gy, wx, wy;
	logic [31:0]                  wxy;
	logic [RW-1:0]                x2, y2, col, row;
	logic [AW-1:0]                row_base, rd_addr, wr_addr;
	logic [tvn_pkg::SCALED_W-1:0] shifted;
	logic [tvn_pkg::OUT_W-1:0]    sat;
	logic [tvn_pkg::ACC_W-1:0]    fold_add;

	function automatic logic [RW-1:0] mod_step(input logic [RW-1:0] r, input logic bit_in);
		logic [RW:0] t;
		t = {r, bit_in};
		if (t >= SIDE_R) begin
			t = t - SIDE_R;
		end
		return t[RW-1:0];
	endfunction

	// octave geometry
	assign k_cur = 3'(b_q - BIT_LOW);
	assign xs    = {x_q, 7'b0} >> k_cur;
	assign ys    = {y_q, 7'b0} >> k_cur;
	assign fx    = xs[14:0];
	assign fy    = ys[14:0];
	assign gx    = tvn_pkg::ONE_Q15 - {1'b0, fx};
	assign gy    = tvn_pkg::ONE_Q15 - {1'b0, fy};
	assign wx    = corner_q[0] ? gx : {1'b0, fx};
	assign wy    = corner_q[1] ? gy : {1'b0, fy};
	assign wxy   = {16'b0, wx} * {16'b0, wy};

	// wrapped lower neighbour
	assign x2  = (rx_q == '0) ? SIDE_M1 : rx_q - 1'b1;
	assign y2  = (ry_q == '0) ? SIDE_M1 : ry_q - 1'b1;
	assign col = corner_q[0] ? x2 : rx_q;
	assign row = corner_q[1] ? y2 : ry_q;
	assign row_base = AW'(row) * AW'(TABLE_SIDE);
	assign rd_addr  = row_base + AW'(col);
	assign wr_addr  = AW'(cmd.index);

	assign reduce_done = (b_q <= BIT_LOW + {2'b00, top_q});
	assign pipe_empty  = !v_s1 && !v_s2 && !fold_s3;

	assign shifted  = scaled_q >> (BIT_LOW + {2'b00, top_q});
	assign sat      = (shifted > tvn_pkg::SCALED_W'(tvn_pkg::OUT_MAX)) ? tvn_pkg::OUT_MAX :
		shifted[tvn_pkg::OUT_W-1:0];
	assign fold_add = tvn_pkg::ACC_W'({8'b0, ssum_q[45:30]} << k_s3);

	always_comb begin
		state_d = state_q;
		case (state_q)
			tvn_pkg::ST_IDLE: begin
				if (cmd_valid && cmd.kind == tvn_pkg::CMD_QUERY) begin
					state_d = tvn_pkg::ST_REDUCE;
				end
			end
			tvn_pkg::ST_REDUCE: begin
				if (reduce_done) begin
					state_d = tvn_pkg::ST_READ;
				end
			end
			tvn_pkg::ST_READ: begin
				if (corner_q == 2'd3) begin
					state_d = (b_q == BIT_LOW) ? tvn_pkg::ST_DRAIN : tvn_pkg::ST_REDUCE;
				end
			end
			tvn_pkg::ST_DRAIN: begin
				if (pipe_empty) begin
					state_d = tvn_pkg::ST_SCALE;
				end
			end
			tvn_pkg::ST_SCALE: state_d = tvn_pkg::ST_OUT;
			tvn_pkg::ST_OUT: begin
				if (!out_valid_q || !out_stall) begin
					state_d = tvn_pkg::ST_IDLE;
				end
			end
			default: state_d = tvn_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		pop      = 1'b0;
		issue    = 1'b0;
		out_load = 1'b0;
		case (state_q)
			tvn_pkg::ST_IDLE: pop      = cmd_valid;
			tvn_pkg::ST_READ: issue    = 1'b1;
			tvn_pkg::ST_OUT:  out_load = !out_valid_q || !out_stall;
			default: begin
				pop = 1'b0;
			end
		endcase
	end

	assign start  = pop && (cmd.kind == tvn_pkg::CMD_QUERY);
	assign mem_we = pop && (cmd.kind == tvn_pkg::CMD_WRITE);

	always_ff @(posedge clk) begin
		if (mem_we) begin
			noise_mem[wr_addr] <= cmd.value;
		end
		if (issue) begin
			rdata_s1 <= noise_mem[rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			x_q   <= cmd.x;
			y_q   <= cmd.y;
			top_q <= top;
			rx_q  <= '0;
			ry_q  <= '0;
			acc_q <= '0;
		end else begin
			if (state_q == tvn_pkg::ST_REDUCE) begin
				rx_q <= mod_step(rx_q, x_q[b_q]);
				ry_q <= mod_step(ry_q, y_q[b_q]);
			end
			if (fold_s3) begin
				acc_q <= acc_q + fold_add;
			end
		end
		weight_s1 <= wxy[tvn_pkg::WGT_W-1:0];
		first_s1  <= (corner_q == 2'd0);
		last_s1   <= (corner_q == 2'd3);
		k_s1      <= k_cur;
		prod_s2   <= {16'b0, weight_s1} * {31'b0, rdata_s1};
		first_s2  <= first_s1;
		last_s2   <= last_s1;
		k_s2      <= k_s1;
		k_s3      <= k_s2;
		if (v_s2) begin
			ssum_q <= first_s2 ? prod_s2 : ssum_q + prod_s2;
		end
		if (state_q == tvn_pkg::ST_SCALE) begin
			scaled_q <= {16'b0, acc_q} * {24'b0, gain};
		end
		if (out_load) begin
			turb_q <= sat;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= tvn_pkg::ST_IDLE;
			b_q         <= BIT_TOP;
			corner_q    <= '0;
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			fold_s3     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (start) begin
				b_q <= BIT_TOP;
			end else if (state_q == tvn_pkg::ST_REDUCE && !reduce_done) begin
				b_q <= b_q - 1'b1;
			end else if (issue && corner_q == 2'd3 && b_q != BIT_LOW) begin
				b_q <= b_q - 1'b1;
			end
			corner_q <= issue ? corner_q + 1'b1 : 2'd0;
			v_s1     <= issue;
			v_s2     <= v_s1;
			fold_s3  <= v_s2 && last_s2;
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign stat.pop   = pop;
	assign stat.busy  = (state_q != tvn_pkg::ST_IDLE);
	assign out_valid  = out_valid_q;
	assign turbulence = turb_q;

endmodule
